FILE: rtl/jpc_pkg.sv
// jpc_pkg: shared constants and the arctangent table of the joystick polar converter.
// No dependencies.
`default_nettype none
package jpc_pkg;
	localparam int FULL_SCALE = 4096;
	localparam int GUARD_BITS = 16;
	localparam logic [12:0] DEADZONE_RST = 13'd205;
	localparam logic [5:0]  SPEED_MAX_RST = 6'd30;
	localparam logic [0:0]  REG_DEADZONE = 1'b0;
	localparam logic [0:0]  REG_SPEED_MAX = 1'b1;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turn32(input int i);
		logic [31:0] t;
		begin
			case (i)
				0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
				3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
				6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
				9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
				12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
				15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
				18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
				21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
				default: t = 32'd0;
			endcase
			return t;
		end
	endfunction
endpackage
`default_nettype wire

FILE: rtl/jpc_front.sv
// jpc_front: accepts sample pairs, centers them and writes them to a small queue.
// Depends on jpc_pkg.
`default_nettype none
module jpc_front import jpc_pkg::*; #(
	parameter int ADC_BITS = 12,
	parameter int DEPTH_LOG = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [ADC_BITS-1:0] x_sample,
	input  wire logic [ADC_BITS-1:0] y_sample,
	output      logic                q_valid,
	input  wire logic                q_pop,
	output      logic signed [ADC_BITS:0] q_x,
	output      logic signed [ADC_BITS:0] q_y
);
	localparam int DEPTH = 1 << DEPTH_LOG;
	logic signed [ADC_BITS:0] xq_q [DEPTH];
	logic signed [ADC_BITS:0] yq_q [DEPTH];
	logic [DEPTH_LOG-1:0] wp_q, rp_q;
	logic [DEPTH_LOG:0]   cnt_q;
	logic push;
	localparam logic signed [ADC_BITS:0] MID = (ADC_BITS+1)'(1 << (ADC_BITS-1));

	assign in_stall = (cnt_q == (DEPTH_LOG+1)'(DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != '0);
	assign q_x = xq_q[rp_q];
	assign q_y = yq_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			xq_q[wp_q] <= $signed({1'b0, x_sample}) - MID;
			yq_q[wp_q] <= $signed({1'b0, y_sample}) - MID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (DEPTH_LOG+1)'(push) - (DEPTH_LOG+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/jpc_back.sv
// jpc_back: pipelined CORDIC angle, square root magnitude, deadzone and speed.
// Depends on jpc_pkg.
`default_nettype none
module jpc_back import jpc_pkg::*; #(
	parameter int ADC_BITS = 12,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	output      logic                  q_pop,
	input  wire logic signed [ADC_BITS:0] q_x,
	input  wire logic signed [ADC_BITS:0] q_y,
	input  wire logic [12:0]           deadzone,
	input  wire logic [5:0]            speed_max,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [15:0]           angle,
	output      logic [12:0]           magnitude,
	output      logic [17:0]           speed
);
	// square of radius, pre-scaled so root gives magnitude directly
	localparam int SW = 2*ADC_BITS + 2 + ((ADC_BITS <= 13) ? 2*(13-ADC_BITS) : 0);
	localparam int RSTEPS = (SW + 1) / 2;
	localparam int RW = RSTEPS;
	localparam int SH = (ADC_BITS > 13) ? ADC_BITS - 13 : 0;
	localparam int CW = ADC_BITS + GUARD_BITS + 4;
	localparam int NS = CORDIC_STEPS;
	localparam int L = NS + 1; // pipeline length; CORDIC and root share stages
	localparam int RPS = (RSTEPS + NS - 1) / NS; // root bits per stage

	logic adv;
	logic [L:0] v_s;
	logic signed [CW-1:0] u_s [NS+1];
	logic signed [CW-1:0] w_s [NS+1];
	logic [ANGLE_BITS-1:0] z_s [NS+1];
	logic [SW-1:0] rem_s [NS+1];
	logic [RW-1:0] root_s [NS+1];
	logic [SW-1:0] sq_s [NS+1];

	// out register holds while stalled; whole pipe moves together
	assign adv = !out_valid || !out_stall;
	assign q_pop = adv && q_valid;

	// stage 0: square sum and pre-rotation
	logic signed [2*ADC_BITS+1:0] xx, yy;
	logic signed [CW-1:0] u0, w0;
	always_comb begin
		xx = (2*ADC_BITS+2)'(q_x) * (2*ADC_BITS+2)'(q_x);
		yy = (2*ADC_BITS+2)'(q_y) * (2*ADC_BITS+2)'(q_y);
		u0 = -(CW'(q_y) <<< GUARD_BITS);
		w0 = -(CW'(q_x) <<< GUARD_BITS);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= (SW'(xx) + SW'(yy)) << ((ADC_BITS <= 13) ? 2*(13-ADC_BITS) : 0);
			rem_s[0] <= '0;
			root_s[0] <= '0;
			if (u0 < 0) begin
				u_s[0] <= -u0;
				w_s[0] <= -w0;
				z_s[0] <= ANGLE_BITS'(1) << (ANGLE_BITS-1);
			end else begin
				u_s[0] <= u0;
				w_s[0] <= w0;
				z_s[0] <= '0;
			end
		end
	end

	// CORDIC step k and RPS digits of restoring square root per stage
	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam logic [ANGLE_BITS-1:0] STEP = ANGLE_BITS'(
			(64'(atan_turn32(k)) + (64'd1 << (31-ANGLE_BITS))) >> (32-ANGLE_BITS));
		logic [SW-1:0] rm, sq;
		logic [RW-1:0] rt;
		logic [SW+1:0] trial;
		always_comb begin
			rm = rem_s[k];
			rt = root_s[k];
			sq = sq_s[k];
			trial = '0;
			for (int j = 0; j < RPS; j++) begin
				if (k*RPS + j < RSTEPS) begin
					rm = (rm << 2) | SW'(sq[SW-1 -: 2]);
					sq = sq << 2;
					trial = (SW+2)'({rt, 2'b01});
					if ((SW+2)'(rm) >= trial) begin
						rm = SW'((SW+2)'(rm) - trial);
						rt = (rt << 1) | RW'(1);
					end else begin
						rt = rt << 1;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1] <= rm;
				root_s[k+1] <= rt;
				sq_s[k+1] <= sq;
				if (!w_s[k][CW-1]) begin
					u_s[k+1] <= u_s[k] + (w_s[k] >>> k);
					w_s[k+1] <= w_s[k] - (u_s[k] >>> k);
					z_s[k+1] <= z_s[k] + STEP;
				end else begin
					u_s[k+1] <= u_s[k] - (w_s[k] >>> k);
					w_s[k+1] <= w_s[k] + (u_s[k] >>> k);
					z_s[k+1] <= z_s[k] - STEP;
				end
			end
		end
	end

	// final stage: deadzone, saturation, angle zeroing, speed
	logic [RW-1:0] mraw;
	logic [12:0] mag;
	always_comb begin
		mraw = root_s[NS] >> SH;
		if (mraw < RW'(deadzone)) mag = '0;
		else if (mraw > RW'(FULL_SCALE)) mag = 13'(FULL_SCALE);
		else mag = 13'(mraw);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			magnitude <= mag;
			angle <= (mag == '0) ? 16'd0 : 16'(z_s[NS]);
			speed <= 18'(speed_max) * 18'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s <= '0;
		else if (adv) v_s <= {v_s[L-1:0], q_valid};
	end
	assign out_valid = v_s[L];
endmodule
`default_nettype wire

FILE: rtl/joystick_polar_converter.sv
// joystick_polar_converter: top level, register file plus front queue and back pipeline.
// Depends on jpc_pkg, jpc_front, jpc_back.
//
// channel | signals                              | direction
// in      | in_valid, in_stall, x/y_sample       | sample pair in
// out     | out_valid, out_stall, angle/mag/speed| polar result out
// cfg     | APB psel..pready                     | deadzone, speed_max
//
// One transfer per cycle in and out unless in_stall or out_stall holds it; a
// result passes through the queue into the pre-rotation stage, CORDIC_STEPS
// rotation stages, then the output register. Rotation stages also do one square
// root digit each at the default widths until all digits are done. A stalled
// output freezes the whole back pipeline; the two entry queue keeps accepting
// until full. Reset at once empties the queue and valid bits and loads register defaults.
`default_nettype none
module joystick_polar_converter import jpc_pkg::*; #(
	parameter int ADC_BITS = 12,
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [ADC_BITS-1:0] x_sample,
	input  wire logic [ADC_BITS-1:0] y_sample,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [15:0]         angle,
	output      logic [12:0]         magnitude,
	output      logic [17:0]         speed,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready
);
	logic [12:0] deadzone_q;
	logic [5:0]  speed_max_q;
	logic q_valid, q_pop;
	logic signed [ADC_BITS:0] q_x, q_y;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadzone_q <= DEADZONE_RST;
			speed_max_q <= SPEED_MAX_RST;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_DEADZONE) deadzone_q <= pwdata[12:0];
			else speed_max_q <= pwdata[5:0];
		end
	end
	always_comb begin
		case (paddr[2])
			REG_DEADZONE:  prdata = {19'd0, deadzone_q};
			REG_SPEED_MAX: prdata = {26'd0, speed_max_q};
			default:       prdata = '0;
		endcase
	end

	jpc_front #(.ADC_BITS(ADC_BITS), .DEPTH_LOG(1)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .x_sample, .y_sample,
		.q_valid, .q_pop, .q_x, .q_y
	);

	jpc_back #(.ADC_BITS(ADC_BITS), .ANGLE_BITS(ANGLE_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_x, .q_y,
		.deadzone(deadzone_q), .speed_max(speed_max_q),
		.out_valid, .out_stall, .angle, .magnitude, .speed
	);
endmodule
`default_nettype wire

FILE: rtl/jpc_checker.sv
// jpc_checker: port level checks of the converter, bound to the top level.
// Depends on joystick_polar_converter ports only.
`default_nettype none
module jpc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] angle,
	input wire logic [12:0] magnitude,
	input wire logic [17:0] speed
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(magnitude))
		else $error("stalled result changed");
	a_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude <= 13'd4096) else $error("magnitude over full scale");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && magnitude == 13'd0 |-> angle == 16'd0 && speed == 18'd0)
		else $error("nonzero angle or speed at zero magnitude");
endmodule

bind joystick_polar_converter jpc_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .angle, .magnitude, .speed
);
`default_nettype wire

FILE: verif/tb_joystick_polar_converter.sv
// tb_joystick_polar_converter: self-checking bench for the joystick polar converter.
// Depends on jpc_pkg and joystick_polar_converter; predicts every polar result in-bench.
`default_nettype none
module tb_joystick_polar_converter;
	import jpc_pkg::*;

	localparam int WDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;   // extra wait after the last expected result

	// register byte addresses
	localparam logic [2:0] ADDR_DEADZONE = 3'(4 * REG_DEADZONE);
	localparam logic [2:0] ADDR_SPEED_MAX = 3'(4 * REG_SPEED_MAX);

	typedef struct packed {
		logic [15:0] angle;
		logic [12:0] magnitude;
		logic [17:0] speed;
	} polar_t;

	typedef struct {
		logic [11:0] x;
		logic [11:0] y;
		bit          known;     // expected result typed in
		polar_t      res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [11:0] x_sample = '0;
	logic [11:0] y_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] angle;
	logic [12:0] magnitude;
	logic [17:0] speed;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	joystick_polar_converter u_dut (.*);

	always #1 clk = ~clk;

	// bench copy of the registers
	logic [12:0] cur_deadzone = DEADZONE_RST;
	logic [5:0]  cur_speed_max = SPEED_MAX_RST;

	polar_t pending_polar[$];
	int errors = 0;
	int n_sent = 0, n_recv = 0, n_zero = 0, n_sat = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;

	function automatic logic [25:0] int_sqrt(input logic [25:0] n);
		logic [25:0] root, bitv, rem;
		begin
			root = 0;
			rem = n;
			bitv = 26'h1 << 24;
			while (bitv > rem) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rem >= root + bitv) begin
					rem = rem - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		end
	endfunction

	// CORDIC vectoring on (-y,-x)<<16; angle measured from +y toward x, plus a half turn
	function automatic logic [15:0] polar_angle(input int x, input int y);
		longint u, v, du, dv;
		logic [15:0] z;
		longint stepang;
		begin
			u = -longint'(y) * 65536;
			v = -longint'(x) * 65536;
			z = 0;
			if (u < 0) begin
				u = -u;
				v = -v;
				z = 16'h8000;
			end
			for (int i = 0; i < 16; i++) begin
				stepang = (longint'(atan_turn32(i)) + (64'd1 << 15)) >> 16;
				du = v >>> i;
				dv = u >>> i;
				if (v >= 0) begin
					u = u + du;
					v = v - dv;
					z = z + 16'(stepang);
				end else begin
					u = u - du;
					v = v + dv;
					z = z - 16'(stepang);
				end
			end
			return z;
		end
	endfunction

	function automatic polar_t predict_polar(input logic [11:0] xs, input logic [11:0] ys);
		int x, y;
		logic [25:0] mag;
		polar_t r;
		begin
			x = int'(xs) - 2048;
			y = int'(ys) - 2048;
			mag = int_sqrt(26'(x * x + y * y) << 2);
			if (mag < cur_deadzone) mag = 0;
			if (mag > FULL_SCALE) mag = FULL_SCALE;
			r.magnitude = 13'(mag);
			r.angle = (mag != 0) ? polar_angle(x, y) : 16'd0;
			r.speed = 18'(cur_speed_max * mag);
			return r;
		end
	endfunction

	// APB write: setup then access, register updates on the access edge
	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		begin
			@(negedge clk);
			psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			@(negedge clk);
			psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
			if (addr == ADDR_DEADZONE) cur_deadzone = data[12:0];
			else if (addr == ADDR_SPEED_MAX) cur_speed_max = data[5:0];
		end
	endtask

	// one input transfer; valid stays up across back-to-back items
	task automatic send_pair(input logic [11:0] xs, input logic [11:0] ys, input bit known,
			input polar_t res);
		polar_t p;
		begin
			while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			x_sample <= xs;
			y_sample <= ys;
			p = predict_polar(xs, ys);
			if (known && p != res)
				$display("%0t table row disagrees with predictor x=%0d y=%0d", $time, xs, ys);
			pending_polar.push_back(known ? res : p);
			@(posedge clk);
			while (in_stall) @(posedge clk);
			n_sent++;
			@(negedge clk);
		end
	endtask

	task automatic wait_idle();
		begin
			in_valid <= 1'b0;
			while (pending_polar.size() != 0) @(negedge clk);
			repeat (DRAIN_CYCLES) @(negedge clk);
		end
	endtask

	// receiver stall, random or one long hold-off
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= (recv_idle_pct != 0) && ($urandom_range(99, 0) < recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		polar_t exp_r;
		if (out_valid && !out_stall && arst_n) begin
			n_recv++;
			if (pending_polar.size() == 0) begin
				errors++;
				$display("%0t unexpected result angle=%0d mag=%0d speed=%0d", $time,
					angle, magnitude, speed);
			end else begin
				exp_r = pending_polar.pop_front();
				if (magnitude == 0) n_zero++;
				if (magnitude == FULL_SCALE) n_sat++;
				if (angle !== exp_r.angle) begin
					errors++;
					$display("%0t angle mismatch: expected %0d actual %0d", $time,
						exp_r.angle, angle);
				end
				if (magnitude !== exp_r.magnitude) begin
					errors++;
					$display("%0t magnitude mismatch: expected %0d actual %0d", $time,
						exp_r.magnitude, magnitude);
				end
				if (speed !== exp_r.speed) begin
					errors++;
					$display("%0t speed mismatch: expected %0d actual %0d", $time,
						exp_r.speed, speed);
				end
			end
		end
	end

	// watchdog on cycles with no input or output transfer and no register access
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WDOG_LIMIT) begin
			$display("%0t watchdog expired, %0d results outstanding", $time, pending_polar.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// random part: mostly uniform pairs, some near the centre, some with x at an edge
	task automatic random_pairs(input int count);
		logic [11:0] xs, ys;
		int pick;
		polar_t none;
		begin
			none = '0;
			for (int k = 0; k < count; k++) begin
				pick = $urandom_range(9, 0);
				if (pick < 6) begin
					xs = 12'($urandom);
					ys = 12'($urandom);
				end else if (pick < 9) begin
					xs = 12'(2048 + $signed(11'($urandom_range(600, 0))) - 300);
					ys = 12'(2048 + $urandom_range(600, 0) - 300);
				end else begin
					xs = ($urandom_range(1, 0) != 0) ? 12'hFFF : 12'h000;
					ys = 12'($urandom);
				end
				send_pair(xs, ys, 0, none);
			end
		end
	endtask

	row_t dir_rows[$];

	function automatic row_t mk(input int xs, input int ys, input bit known, input int a,
			input int m, input int s);
		row_t r;
		begin
			r.x = 12'(xs); r.y = 12'(ys); r.known = known;
			r.res.angle = 16'(a); r.res.magnitude = 13'(m); r.res.speed = 18'(s);
			return r;
		end
	endfunction

	initial begin
		polar_t none;
		none = '0;
		// directed stimulus under reset register values
		dir_rows = '{
			mk(2048, 2048, 1, 0, 0, 0),          // centre
			mk(2100, 2048, 1, 0, 0, 0),          // inside deadzone
			mk(2048, 2048 + 102, 1, 0, 0, 0),    // just below deadzone (mag 204)
			mk(2048, 2048 + 103, 0, 0, 0, 0),    // just at deadzone edge
			mk(4095, 4095, 1, polar_angle(2047, 2047), 4096, 122880), // corner saturates
			mk(0, 0, 0, 0, 0, 0),
			mk(0, 4095, 0, 0, 0, 0),
			mk(4095, 0, 0, 0, 0, 0),
			mk(2048, 4095, 0, 0, 0, 0),          // +y axis
			mk(2048, 0, 0, 0, 0, 0),             // -y axis
			mk(4095, 2048, 0, 0, 0, 0),          // +x axis
			mk(0, 2048, 0, 0, 0, 0),             // -x axis
			mk(2047, 0, 0, 0, 0, 0),
			mk(2049, 0, 0, 0, 0, 0),
			mk(3072, 2048, 0, 0, 0, 0),
			mk(2048, 1024, 0, 0, 0, 0),
			mk(2730, 3413, 0, 0, 0, 0),
			mk(1365, 682, 0, 0, 0, 0),
			mk(12'hAAA, 12'h555, 0, 0, 0, 0),
			mk(12'h555, 12'hAAA, 0, 0, 0, 0)
		};
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		foreach (dir_rows[i]) send_pair(dir_rows[i].x, dir_rows[i].y, dir_rows[i].known,
			dir_rows[i].res);
		wait_idle();

		// deadzone zero: nothing suppressed; speed_max full
		reg_write(ADDR_DEADZONE, 32'd0);
		reg_write(ADDR_SPEED_MAX, 32'd63);
		send_pair(2048, 2049, 0, none);
		send_pair(2048, 2048, 1, none);       // centre still all zero
		send_pair(0, 0, 0, none);
		send_pair(4095, 4095, 1, '{angle: polar_angle(2047, 2047), magnitude: 13'd4096,
			speed: 18'd258048});
		send_pair(2049, 2048, 0, none);
		wait_idle();

		// deadzone above every raw magnitude: every result all zero
		reg_write(ADDR_DEADZONE, 32'd8191);
		reg_write(ADDR_SPEED_MAX, 32'd0);
		send_pair(4095, 4095, 1, none);
		send_pair(0, 0, 1, none);
		random_pairs(30);
		wait_idle();

		// phase A: sender idles lightly, receiver heavily
		reg_write(ADDR_DEADZONE, 32'd4096);
		reg_write(ADDR_SPEED_MAX, 32'd1);
		send_idle_pct = 27; recv_idle_pct = 80;
		random_pairs(300);
		wait_idle();

		// phase B: the other way round, with a long receiver hold-off first
		reg_write(ADDR_DEADZONE, 32'($urandom_range(400, 0)));
		reg_write(ADDR_SPEED_MAX, 32'($urandom_range(63, 0)));
		send_idle_pct = 80; recv_idle_pct = 27;
		fork
			begin
				hold_off = 1;
				repeat (200) @(negedge clk);
				hold_off = 0;
			end
			begin
				send_idle_pct = 0;
				random_pairs(40);
				in_valid <= 1'b0;
				send_idle_pct = 80;
			end
		join
		random_pairs(360);
		wait_idle();

		// phase C: no idling
		reg_write(ADDR_DEADZONE, 32'd205);
		reg_write(ADDR_SPEED_MAX, 32'd30);
		send_idle_pct = 0; recv_idle_pct = 0;
		random_pairs(400);
		wait_idle();

		$display("Covered %0d sample pairs, %0d results (%0d zero, %0d saturated),",
			n_sent, n_recv, n_zero, n_sat);
		$display("under deadzone 0..8191 and speed_max 0..63 with varied back-pressure.");
		if (errors == 0 && pending_polar.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: joystick_polar_converter.f
rtl/jpc_pkg.sv
rtl/jpc_front.sv
rtl/jpc_back.sv
rtl/joystick_polar_converter.sv
rtl/jpc_checker.sv
verif/tb_joystick_polar_converter.sv
